// ===== rtl/swept_box_collision_mover_macros.svh =====
// ---------------------------------------------------------------------------
// swept box mover assertion macros
// shared property wrappers for the rtl assertions
// ---------------------------------------------------------------------------
`ifndef SWEPT_BOX_COLLISION_MOVER_MACROS_SVH
`define SWEPT_BOX_COLLISION_MOVER_MACROS_SVH

// implication checked on every clock, off in reset
`define SBM_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sbm assertion failed");

// next-cycle implication
`define SBM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("sbm assertion failed");

`endif

// ===== rtl/sbm_pkg.sv =====
// ---------------------------------------------------------------------------
// sbm_pkg
// types and constants of the swept box mover
// ---------------------------------------------------------------------------
package sbm_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;

    localparam logic REG_GRAVITY  = 1'b0;
    localparam logic REG_MAX_FALL = 1'b1;

    localparam logic [3:0] GRAVITY_RESET  = 4'd1;
    localparam logic [6:0] MAX_FALL_RESET = 7'd20;

    localparam int IN_W  = 88;
    localparam int OUT_W = 56;

    typedef enum logic [1:0]
    {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef struct packed
    {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [10:0]        hw;
        logic [10:0]        hh;
    } sbox_t;

    typedef struct packed
    {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [7:0]  new_vel_x;
        logic signed [7:0]  new_vel_y;
        logic               landed;
        logic               over_left_edge;
        logic               over_right_edge;
    } result_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7fff;
        else if (v < -20'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [7:0] sat8(input logic signed [19:0] v);
        if (v > 20'sd127)
            return 8'sh7f;
        else if (v < -20'sd128)
            return 8'sh80;
        else
            return v[7:0];
    endfunction

endpackage

// ===== rtl/swept_box_collision_mover.sv =====
// ---------------------------------------------------------------------------
// swept_box_collision_mover
// box mover with a table of static boxes and four swept collision passes
// ---------------------------------------------------------------------------
// s_axis carries items: op 0 loads a static slot, op 1 clears it, op 2
// moves a box. load and clear give no result. a move adds gravity, then
// runs right, left, up and down sweeps; each sweep reads every table
// slot from a single-port memory, one per cycle. one move result leaves
// on m_axis.
// one item is worked on at a time; s_axis_tready is low while busy.
// the result waits in an output register while m_axis_tready is low and
// the block may take and finish the next load or clear meanwhile; a new
// move waits until the held result is taken.
// cfg writes (index 0 gravity_step, 1 max_fall_speed) are always accepted.
// reset empties the table through valid flops at once and restores the
// register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "swept_box_collision_mover_macros.svh"

module swept_box_collision_mover #(
    parameter int MAX_STATIC = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // op[1:0] slot[7:2] pos_x[23:8] pos_y[39:24] box_width[51:40]
    // box_height[63:52] vel_x[71:64] vel_y[79:72] timed_projectile[80]
    input  logic [sbm_pkg::IN_W-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // new_x[15:0] new_y[31:16] new_vel_x[39:32] new_vel_y[47:40]
    // landed[48] over_left_edge[49] over_right_edge[50]
    output logic [sbm_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [6:0]              cfg_data
);
    import sbm_pkg::*;

    localparam int AW = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    sbox_t                 mem [MAX_STATIC];
    logic [MAX_STATIC-1:0] valid_reg;
    sbox_t                 rd_data_reg;
    logic                  rd_valid_reg;
    logic [AW:0]           addr_reg;
    logic                  issue_done_reg;

    logic [3:0] gravity_reg;
    logic [6:0] max_fall_reg;

    logic [1:0]  op_in;
    logic [5:0]  slot_in;
    logic        slot_ok;
    logic [5:0]  slot_reg;
    logic        wr_load_reg;
    sbox_t       wr_box_reg;

    logic signed [15:0] mx_reg, my_reg;
    logic [10:0]        mhw_reg, mhh_reg;
    logic signed [7:0]  mvx_reg;
    logic signed [8:0]  mvy_reg;
    logic               timed_reg;
    logic               landed_reg, out_l_reg, out_r_reg;
    dir_t               dir_reg;
    logic signed [19:0] pm_reg;

    // per-sweep edges of the mover
    logic signed [19:0] rd, ld, td, dd, vx20, vy20;
    logic signed [19:0] ls, rs, ts, ds;
    logic               hit;
    logic signed [19:0] pm_hit;
    logic               active;
    logic signed [19:0] vy_g;
    logic signed [19:0] pm_fin, npos;

    result_t res_reg;
    logic    out_valid_reg;

    assign op_in   = s_axis_tdata[1:0];
    assign slot_in = s_axis_tdata[7:2];
    assign slot_ok = ({26'd0, slot_in} < 32'(MAX_STATIC));

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= GRAVITY_RESET;
            max_fall_reg <= MAX_FALL_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_GRAVITY)
                gravity_reg <= cfg_data[3:0];
            else
                max_fall_reg <= cfg_data;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           !(out_valid_reg && (op_in == OP_MOVE));

    always_comb
    begin
        rd   = 20'(mx_reg) + 20'(mhw_reg);
        ld   = 20'(mx_reg) - 20'(mhw_reg);
        td   = 20'(my_reg) - 20'(mhh_reg);
        dd   = 20'(my_reg) + 20'(mhh_reg);
        vx20 = 20'(mvx_reg);
        vy20 = 20'(mvy_reg);
        ls   = 20'(rd_data_reg.x) - 20'(rd_data_reg.hw);
        rs   = 20'(rd_data_reg.x) + 20'(rd_data_reg.hw);
        ts   = 20'(rd_data_reg.y) - 20'(rd_data_reg.hh);
        ds   = 20'(rd_data_reg.y) + 20'(rd_data_reg.hh);
        hit    = 1'b0;
        pm_hit = pm_reg;
        case (dir_reg)
            DIR_RIGHT:
            begin
                active = (mvx_reg > 8'sd0);
                hit = (rd + vx20 >= ls) && (rd <= ls) && (ts < dd) && (ds > td)
                      && (pm_reg >= ls - rd);
                pm_hit = timed_reg ? vx20 : ls - rd;
            end
            DIR_LEFT:
            begin
                active = (mvx_reg < 8'sd0);
                hit = (ld + vx20 <= rs) && (ld >= rs) && (ts < dd) && (ds > td)
                      && (pm_reg <= rs - ld);
                pm_hit = timed_reg ? vx20 : rs - ld;
            end
            DIR_UP:
            begin
                active = (mvy_reg < 9'sd0);
                hit = (td + vy20 <= ds) && (dd > ts) && (ld < rs) && (rd > ls)
                      && (pm_reg <= ds - td);
                pm_hit = timed_reg ? vy20 : ds - td;
            end
            DIR_DOWN:
            begin
                active = (mvy_reg > 9'sd0);
                hit = (dd + vy20 >= ts) && (td < ds) && (ld < rs) && (rd > ls)
                      && (pm_reg >= ts - dd);
                pm_hit = timed_reg ? vy20 : ts - dd;
            end
            default:
            begin
                active = 1'b0;
            end
        endcase
        hit = hit && active && rd_valid_reg;

        pm_fin = pm_reg;
        if ((dir_reg == DIR_DOWN) && (pm_reg < 20'sd0))
            pm_fin = 20'sd0;
        if ((dir_reg == DIR_RIGHT) || (dir_reg == DIR_LEFT))
            npos = 20'(mx_reg) + pm_fin;
        else
            npos = 20'(my_reg) + pm_fin;

        vy_g = 20'(signed'(s_axis_tdata[79:72])) + $signed({16'd0, gravity_reg});
        if (vy_g > $signed({13'd0, max_fall_reg}))
            vy_g = $signed({13'd0, max_fall_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (((op_in == OP_LOAD) || (op_in == OP_CLEAR)) && slot_ok)
                        state_next = ST_WRITE;
                    else if (op_in == OP_MOVE)
                        state_next = ST_SCAN;
                end
            ST_WRITE:
                state_next = ST_IDLE;
            ST_SCAN:
                if (issue_done_reg && !rd_valid_reg)
                    state_next = ST_APPLY;
            ST_APPLY:
                if (dir_reg == DIR_DOWN)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
            mem[AW'(slot_reg)] <= wr_box_reg;
        rd_data_reg <= mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            dir_reg        <= DIR_RIGHT;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            rd_valid_reg <= (state_reg == ST_SCAN) && !issue_done_reg &&
                            valid_reg[addr_reg[AW-1:0]];
            case (state_reg)
                ST_IDLE:
                begin
                    addr_reg       <= '0;
                    issue_done_reg <= 1'b0;
                    dir_reg        <= DIR_RIGHT;
                end
                ST_WRITE:
                    valid_reg[AW'(slot_reg)] <= wr_load_reg;
                ST_SCAN:
                    if (!issue_done_reg)
                    begin
                        if (addr_reg == (AW+1)'(MAX_STATIC - 1))
                            issue_done_reg <= 1'b1;
                        else
                            addr_reg <= addr_reg + 1'b1;
                    end
                ST_APPLY:
                begin
                    addr_reg       <= '0;
                    issue_done_reg <= 1'b0;
                    dir_reg        <= dir_t'(dir_reg + 2'd1);
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                slot_reg      <= slot_in;
                wr_load_reg   <= (op_in == OP_LOAD);
                wr_box_reg.x  <= s_axis_tdata[23:8];
                wr_box_reg.y  <= s_axis_tdata[39:24];
                wr_box_reg.hw <= s_axis_tdata[51:41];
                wr_box_reg.hh <= s_axis_tdata[63:53];
                mx_reg        <= s_axis_tdata[23:8];
                my_reg        <= s_axis_tdata[39:24];
                mhw_reg       <= s_axis_tdata[51:41];
                mhh_reg       <= s_axis_tdata[63:53];
                mvx_reg       <= s_axis_tdata[71:64];
                mvy_reg       <= vy_g[8:0];
                timed_reg     <= s_axis_tdata[80];
                landed_reg    <= 1'b0;
                out_l_reg     <= 1'b1;
                out_r_reg     <= 1'b1;
                pm_reg        <= 20'(signed'(s_axis_tdata[71:64]));
            end
            ST_SCAN:
                if (hit)
                begin
                    pm_reg <= pm_hit;
                    if (dir_reg == DIR_DOWN)
                    begin
                        landed_reg <= 1'b1;
                        if (rd <= rs)
                            out_r_reg <= 1'b0;
                        if (ld >= ls)
                            out_l_reg <= 1'b0;
                    end
                end
            ST_APPLY:
            begin
                if (active)
                begin
                    if ((dir_reg == DIR_RIGHT) || (dir_reg == DIR_LEFT))
                    begin
                        mx_reg  <= sat16(npos);
                        mvx_reg <= sat8(pm_fin);
                    end
                    else
                    begin
                        my_reg  <= sat16(npos);
                        mvy_reg <= 9'(sat8(pm_fin));
                    end
                end
                if (dir_reg == DIR_RIGHT)
                    pm_reg <= (active ? 20'(sat8(pm_fin)) : vx20);
                else if (dir_reg == DIR_LEFT)
                    pm_reg <= vy20;
                else if (active)
                    pm_reg <= 20'(sat8(pm_fin));
                else
                    pm_reg <= vy20;
            end
            ST_DONE:
            begin
                res_reg.new_x           <= mx_reg;
                res_reg.new_y           <= my_reg;
                res_reg.new_vel_x       <= mvx_reg;
                res_reg.new_vel_y       <= mvy_reg[7:0];
                res_reg.landed          <= landed_reg;
                res_reg.over_left_edge  <= out_l_reg;
                res_reg.over_right_edge <= out_r_reg;
            end
            default:
                ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, res_reg.over_right_edge, res_reg.over_left_edge,
                            res_reg.landed, res_reg.new_vel_y, res_reg.new_vel_x,
                            res_reg.new_y, res_reg.new_x};

    `SBM_ASSERT_IMPL(a_busy_not_ready, clk, rst_n,
        state_reg != ST_IDLE, !s_axis_tready)
    `SBM_ASSERT_NEXT(a_done_gives_result, clk, rst_n,
        state_reg == ST_DONE, m_axis_tvalid)
    `SBM_ASSERT_IMPL(a_no_move_over_result, clk, rst_n,
        (state_reg == ST_DONE), !(out_valid_reg && !m_axis_tready))

endmodule

// ===== tb/sv/tb_swept_box_collision_mover.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// swept box mover testbench
// drives load, clear, move and op 3 items with random idling on both sides and
// checks every move result against a predictor of the four sweeps
// ---------------------------------------------------------------------------
module tb_swept_box_collision_mover;
    import sbm_pkg::*;

    typedef struct packed
    {
        logic [1:0]         op;
        logic [5:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        box_w;
        logic [11:0]        box_h;
        logic signed [7:0]  vel_x;
        logic signed [7:0]  vel_y;
        logic               timed;
    } cmd_t;

    typedef struct
    {
        int x;
        int y;
        int hw;
        int hh;
        int vx;
        int vy;
        bit timed;
        bit landed;
        bit out_l;
        bit out_r;
    } body_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [6:0] cfg_data;

    cmd_t    pending_items[$];
    result_t expected_moves[$];
    bit      tbl_valid[64];
    int      tbl_x[64];
    int      tbl_y[64];
    int      tbl_hw[64];
    int      tbl_hh[64];
    int      gravity;
    int      fall_limit;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      rx_hold;
    int      hold_req = 0;
    int      hold_ack;
    bit      failed = 1'b0;

    swept_box_collision_mover dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic result_t predict_move(cmd_t c);
        body_t   m;
        result_t r;
        int      pm;
        int      a;
        int      b;
        int      t;
        int      d;
        int      ls;
        int      rs;
        int      ts;
        int      ds;
        m.x = c.pos_x;
        m.y = c.pos_y;
        m.hw = c.box_w >> 1;
        m.hh = c.box_h >> 1;
        m.vx = c.vel_x;
        m.vy = int'(c.vel_y) + gravity;
        if (m.vy > fall_limit)
            m.vy = fall_limit;
        m.timed = c.timed;
        m.landed = 0;
        m.out_l = 1;
        m.out_r = 1;
        // right
        if (m.vx > 0)
        begin
            pm = m.vx;
            a = m.x + m.hw; t = m.y - m.hh; d = m.y + m.hh;
            for (int i = 0; i < 64; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                ls = tbl_x[i] - tbl_hw[i]; ts = tbl_y[i] - tbl_hh[i];
                ds = tbl_y[i] + tbl_hh[i];
                if (a + m.vx >= ls && a <= ls && ts < d && ds > t && pm >= ls - a)
                    pm = m.timed ? m.vx : ls - a;
            end
            m.x = clip(m.x + pm, -32768, 32767);
            m.vx = clip(pm, -128, 127);
        end
        // left
        if (m.vx < 0)
        begin
            pm = m.vx;
            a = m.x - m.hw; t = m.y - m.hh; d = m.y + m.hh;
            for (int i = 0; i < 64; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                rs = tbl_x[i] + tbl_hw[i]; ts = tbl_y[i] - tbl_hh[i];
                ds = tbl_y[i] + tbl_hh[i];
                if (a + m.vx <= rs && a >= rs && ts < d && ds > t && pm <= rs - a)
                    pm = m.timed ? m.vx : rs - a;
            end
            m.x = clip(m.x + pm, -32768, 32767);
            m.vx = clip(pm, -128, 127);
        end
        // up
        if (m.vy < 0)
        begin
            pm = m.vy;
            t = m.y - m.hh; d = m.y + m.hh; a = m.x + m.hw; b = m.x - m.hw;
            for (int i = 0; i < 64; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                ts = tbl_y[i] - tbl_hh[i]; ds = tbl_y[i] + tbl_hh[i];
                rs = tbl_x[i] + tbl_hw[i]; ls = tbl_x[i] - tbl_hw[i];
                if (t + m.vy <= ds && d > ts && b < rs && a > ls && pm <= ds - t)
                    pm = m.timed ? m.vy : ds - t;
            end
            m.y = clip(m.y + pm, -32768, 32767);
            m.vy = clip(pm, -128, 127);
        end
        // down
        if (m.vy > 0)
        begin
            pm = m.vy;
            t = m.y - m.hh; d = m.y + m.hh; a = m.x + m.hw; b = m.x - m.hw;
            for (int i = 0; i < 64; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                ts = tbl_y[i] - tbl_hh[i]; ds = tbl_y[i] + tbl_hh[i];
                rs = tbl_x[i] + tbl_hw[i]; ls = tbl_x[i] - tbl_hw[i];
                if (d + m.vy >= ts && t < ds && b < rs && a > ls && pm >= ts - d)
                begin
                    pm = ts - d;
                    m.landed = 1;
                    if (a <= rs)
                        m.out_r = 0;
                    if (b >= ls)
                        m.out_l = 0;
                    if (m.timed)
                        pm = m.vy;
                end
            end
            if (pm < 0)
                pm = 0;
            m.y = clip(m.y + pm, -32768, 32767);
            m.vy = clip(pm, -128, 127);
        end
        r.new_x = m.x[15:0];
        r.new_y = m.y[15:0];
        r.new_vel_x = m.vx[7:0];
        r.new_vel_y = m.vy[7:0];
        r.landed = m.landed;
        r.over_left_edge = m.out_l;
        r.over_right_edge = m.out_r;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(cmd_t c);
        logic [IN_W-1:0] v;
        v = '0;
        v[1:0] = c.op;
        v[7:2] = c.slot;
        v[23:8] = c.pos_x;
        v[39:24] = c.pos_y;
        v[51:40] = c.box_w;
        v[63:52] = c.box_h;
        v[71:64] = c.vel_x;
        v[79:72] = c.vel_y;
        v[80] = c.timed;
        return v;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_axis_tdata <= pack_item(pending_items[0]);
                s_axis_tvalid <= 1'b1;
                void'(pending_items.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // prediction at acceptance, in acceptance order
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            c.op = s_axis_tdata[1:0];
            c.slot = s_axis_tdata[7:2];
            c.pos_x = s_axis_tdata[23:8];
            c.pos_y = s_axis_tdata[39:24];
            c.box_w = s_axis_tdata[51:40];
            c.box_h = s_axis_tdata[63:52];
            c.vel_x = s_axis_tdata[71:64];
            c.vel_y = s_axis_tdata[79:72];
            c.timed = s_axis_tdata[80];
            if (c.op == OP_LOAD || c.op == OP_CLEAR)
            begin
                tbl_valid[c.slot] = (c.op == OP_LOAD);
                tbl_x[c.slot] = c.op == OP_LOAD ? int'(c.pos_x) : 0;
                tbl_y[c.slot] = c.op == OP_LOAD ? int'(c.pos_y) : 0;
                tbl_hw[c.slot] = c.op == OP_LOAD ? int'(c.box_w >> 1) : 0;
                tbl_hh[c.slot] = c.op == OP_LOAD ? int'(c.box_h >> 1) : 0;
            end
            else if (c.op == OP_MOVE)
                expected_moves = {expected_moves, predict_move(c)};
        end
    end

    // receiver readiness
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= 0;
            hold_ack <= 0;
        end
        else if (hold_ack != hold_req)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= 2000;
            hold_ack <= hold_req;
        end
        else if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
            m_axis_tready <= $urandom_range(99) >= rx_idle_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.new_x = m_axis_tdata[15:0];
            got.new_y = m_axis_tdata[31:16];
            got.new_vel_x = m_axis_tdata[39:32];
            got.new_vel_y = m_axis_tdata[47:40];
            got.landed = m_axis_tdata[48];
            got.over_left_edge = m_axis_tdata[49];
            got.over_right_edge = m_axis_tdata[50];
            if (expected_moves.size() == 0)
            begin
                $error("result with no move pending");
                failed = 1;
            end
            else
            begin
                want = expected_moves.pop_front();
                if (got.new_x !== want.new_x)
                begin
                    $error("new_x exp %0d got %0d", want.new_x, got.new_x);
                    failed = 1;
                end
                if (got.new_y !== want.new_y)
                begin
                    $error("new_y exp %0d got %0d", want.new_y, got.new_y);
                    failed = 1;
                end
                if (got.new_vel_x !== want.new_vel_x)
                begin
                    $error("new_vel_x exp %0d got %0d", want.new_vel_x, got.new_vel_x);
                    failed = 1;
                end
                if (got.new_vel_y !== want.new_vel_y)
                begin
                    $error("new_vel_y exp %0d got %0d", want.new_vel_y, got.new_vel_y);
                    failed = 1;
                end
                if (got.landed !== want.landed)
                begin
                    $error("landed exp %0d got %0d", want.landed, got.landed);
                    failed = 1;
                end
                if (got.over_left_edge !== want.over_left_edge)
                begin
                    $error("over_left_edge exp %0d got %0d",
                        want.over_left_edge, got.over_left_edge);
                    failed = 1;
                end
                if (got.over_right_edge !== want.over_right_edge)
                begin
                    $error("over_right_edge exp %0d got %0d",
                        want.over_right_edge, got.over_right_edge);
                    failed = 1;
                end
            end
        end
    end

    function automatic cmd_t make_cmd(logic [1:0] op, int slot, int px, int py,
                                      int w, int h, int vx, int vy, bit timed);
        cmd_t c;
        c.op = op;
        c.slot = 6'(slot);
        c.pos_x = 16'(px);
        c.pos_y = 16'(py);
        c.box_w = 12'(w);
        c.box_h = 12'(h);
        c.vel_x = 8'(vx);
        c.vel_y = 8'(vy);
        c.timed = timed;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   k;
        c.op = 2'($urandom_range(3));
        c.slot = 6'($urandom_range(63));
        c.pos_x = 16'($urandom());
        c.pos_y = 16'($urandom());
        c.box_w = 12'($urandom());
        c.box_h = 12'($urandom());
        c.vel_x = 8'($urandom());
        c.vel_y = 8'($urandom());
        c.timed = 1'($urandom_range(1));
        k = $urandom_range(99);
        if (k < 10)
            return c;
        // near a small arena so sweeps actually hit boxes
        c.pos_x = 16'(int'($urandom_range(400)) - 200);
        c.pos_y = 16'(int'($urandom_range(400)) - 200);
        c.box_w = 12'($urandom_range(120));
        c.box_h = 12'($urandom_range(120));
        c.vel_x = 8'(int'($urandom_range(100)) - 50);
        c.vel_y = 8'(int'($urandom_range(100)) - 50);
        if (k < 30)
            c.op = OP_LOAD;
        else if (k < 38)
            c.op = OP_CLEAR;
        else
            c.op = OP_MOVE;
        return c;
    endfunction

    task automatic queue_item(cmd_t c);
        pending_items = {pending_items, c};
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GRAVITY)
            gravity = val[3:0];
        else
            fall_limit = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_moves.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            queue_item(random_cmd());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        gravity = int'(GRAVITY_RESET);
        fall_limit = int'(MAX_FALL_RESET);
        tx_idle_pct = 30;
        rx_idle_pct = 53;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: floor, walls, ceiling and extremes
        queue_item(make_cmd(OP_MOVE, 0, 0, 0, 10, 10, 5, 0, 0));
        queue_item(make_cmd(OP_LOAD, 0, 0, 100, 200, 20, 0, 0, 0));
        queue_item(make_cmd(OP_LOAD, 1, 60, 0, 20, 200, 0, 0, 0));
        queue_item(make_cmd(OP_LOAD, 2, -60, 0, 20, 200, 0, 0, 0));
        queue_item(make_cmd(OP_LOAD, 63, 0, -60, 200, 20, 0, 0, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 80, 20, 20, 0, 10, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 80, 20, 20, 0, 10, 1));
        queue_item(make_cmd(OP_MOVE, 0, 0, 0, 20, 20, 127, 0, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 0, 20, 20, -128, 0, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 0, 20, 20, 127, -128, 1));
        queue_item(make_cmd(OP_MOVE, 0, 0, -40, 20, 20, 0, -128, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 95, 20, 20, 0, 3, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 80, 300, 20, 0, 10, 0));
        queue_item(make_cmd(OP_MOVE, 0, 32767, 32767, 4095, 4095, 127, 127, 0));
        queue_item(make_cmd(OP_MOVE, 0, -32768, -32768, 4095, 4095, -128, -128, 1));
        queue_item(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(make_cmd(OP_MOVE, 0, 0, 80, 20, 20, 0, 10, 0));
        queue_item(make_cmd(2'd3, 5, 1, 2, 3, 4, 5, 6, 1));
        queue_item(make_cmd(OP_CLEAR, 63, 0, 0, 0, 0, 0, 0, 0));
        drain();

        write_reg(REG_GRAVITY, 7'd15);
        write_reg(REG_MAX_FALL, 7'd127);
        run_random(250);

        // receiver stalls long while the sender keeps offering
        hold_req = hold_req + 1;
        run_random(100);

        tx_idle_pct = 53;
        rx_idle_pct = 30;
        write_reg(REG_GRAVITY, 7'd0);
        write_reg(REG_MAX_FALL, 7'd0);
        run_random(250);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_GRAVITY, 7'd3);
        write_reg(REG_MAX_FALL, 7'd40);
        run_random(250);
        write_reg(REG_GRAVITY, 7'(GRAVITY_RESET));
        write_reg(REG_MAX_FALL, MAX_FALL_RESET);
        run_random(200);

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
